### hdl/crcbc_pkg.sv
// Shared types, constants and CRC-32 / classification functions for the boot-code classifier.
package crcbc_pkg;

    localparam int CRC_W = 32;
    localparam int BYTE_W = 8;
    localparam int CLASS_W = 3;
    localparam int M_TDATA_W = 40;

    localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0] CRC_ALL_ONES = 32'hFFFF_FFFF;

    localparam logic [CRC_W-1:0] SIG_CLASS1_A = 32'h303F_AAC9;
    localparam logic [CRC_W-1:0] SIG_CLASS1_B = 32'hF0DA_3D50;
    localparam logic [CRC_W-1:0] SIG_CLASS2 = 32'hF310_6101;
    localparam logic [CRC_W-1:0] SIG_CLASS3 = 32'hE7CD_9D51;
    localparam logic [CRC_W-1:0] SIG_CLASS5 = 32'h07AE_65C9;
    localparam logic [CRC_W-1:0] SIG_CLASS6 = 32'h8601_5F8F;

    localparam logic [CLASS_W-1:0] CHIP_CLASS_1 = 3'd1;
    localparam logic [CLASS_W-1:0] CHIP_CLASS_2 = 3'd2;
    localparam logic [CLASS_W-1:0] CHIP_CLASS_3 = 3'd3;
    localparam logic [CLASS_W-1:0] CHIP_CLASS_5 = 3'd5;
    localparam logic [CLASS_W-1:0] CHIP_CLASS_6 = 3'd6;

    typedef struct packed {
        logic [CLASS_W-1:0] chip_class;
        logic [CRC_W-1:0]   crc_value;
    } crcbc_res_t;

    // One byte through the reflected CRC-32 network.
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                   input logic [BYTE_W-1:0] data_in);
        logic [CRC_W-1:0] c;
        c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, data_in};
        for (int k = 0; k < BYTE_W; k++) begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [CLASS_W-1:0] classify(input logic [CRC_W-1:0] crc_in);
        logic [CLASS_W-1:0] cls;
        case (crc_in)
            SIG_CLASS1_A: cls = CHIP_CLASS_1;
            SIG_CLASS1_B: cls = CHIP_CLASS_1;
            SIG_CLASS2:   cls = CHIP_CLASS_2;
            SIG_CLASS3:   cls = CHIP_CLASS_3;
            SIG_CLASS5:   cls = CHIP_CLASS_5;
            SIG_CLASS6:   cls = CHIP_CLASS_6;
            default:      cls = CHIP_CLASS_2;
        endcase
        return cls;
    endfunction

endpackage

### hdl/crcbc_crc_stage.sv
// Input byte register, running CRC state and per-byte CRC update with classification.
module crcbc_crc_stage
    import crcbc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,
    input  logic              s_tuser,
    input  logic              s_tlast,
    input  logic [CRC_W-1:0]  initial_crc,
    output logic              res_valid,
    input  logic              res_ready,
    output crcbc_res_t        res
);

    logic              a_valid_reg;
    logic              a_valid_next;
    logic [BYTE_W-1:0] a_data_reg;
    logic              a_first_reg;
    logic              a_last_reg;
    logic [CRC_W-1:0]  crc_reg;
    logic [CRC_W-1:0]  crc_next;
    logic [CRC_W-1:0]  crc_start;
    logic [CRC_W-1:0]  crc_calc;
    logic [CRC_W-1:0]  crc_final;
    logic              a_fire;
    logic              s_fire;

    assign a_fire    = a_valid_reg && (!a_last_reg || res_ready);
    assign s_tready  = !a_valid_reg || a_fire;
    assign s_fire    = s_tvalid && s_tready;

    assign crc_start = a_first_reg ? ~initial_crc : crc_reg;
    assign crc_calc  = crc_byte(crc_start, a_data_reg);
    assign crc_final = crc_calc ^ CRC_ALL_ONES;

    assign res_valid      = a_valid_reg && a_last_reg;
    assign res.crc_value  = crc_final;
    assign res.chip_class = classify(crc_final);

    always_comb begin
        a_valid_next = a_valid_reg;
        if (s_fire) begin
            a_valid_next = 1'b1;
        end else if (a_fire) begin
            a_valid_next = 1'b0;
        end
        crc_next = a_fire ? crc_calc : crc_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            crc_reg     <= CRC_ALL_ONES;
        end else begin
            a_valid_reg <= a_valid_next;
            crc_reg     <= crc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            a_data_reg  <= s_tdata;
            a_first_reg <= s_tuser;
            a_last_reg  <= s_tlast;
        end
    end

endmodule

### hdl/crcbc_out_reg.sv
// Result register driving the master-side stream.
module crcbc_out_reg
    import crcbc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 res_valid,
    output logic                 res_ready,
    input  crcbc_res_t           res,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic       m_valid_reg;
    logic       m_valid_next;
    crcbc_res_t m_res_reg;

    assign res_ready = !m_valid_reg || m_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {{(M_TDATA_W-CLASS_W-CRC_W){1'b0}}, m_res_reg.chip_class,
                        m_res_reg.crc_value};

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_ready) begin
            m_valid_next = res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_res_reg <= res;
        end
    end

endmodule

### hdl/crc32_boot_code_classifier.sv
// Top level: byte-serial reflected CRC-32 with boot-chip classification.
// Throughput: one byte per cycle, sustained, while m_tready stays high.
// A last byte is registered in the CRC stage, its result then in the output register.
// Running CRC feedback in the CRC stage: one byte per cycle, last bytes wait on res_ready.
// Reset (aresetn low, synchronous): both stages empty, running CRC all ones,
// initial_crc cleared to zero.
module crc32_boot_code_classifier
    import crcbc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CRC_W-1:0]     cfg_wdata,   // initial_crc
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [BYTE_W-1:0]    s_tdata,     // [7:0] data_byte
    input  logic                 s_tuser,     // [0] first_byte
    input  logic                 s_tlast,     // last_byte
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata      // [31:0] crc_value, [34:32] chip_class, pad
);

    logic [CRC_W-1:0] initial_crc_reg;
    logic [CRC_W-1:0] initial_crc_next;
    logic             res_valid;
    logic             res_ready;
    crcbc_res_t       res;

    assign initial_crc_next = cfg_we ? cfg_wdata : initial_crc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            initial_crc_reg <= '0;
        end else begin
            initial_crc_reg <= initial_crc_next;
        end
    end

    crcbc_crc_stage u_crc_stage (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .initial_crc (initial_crc_reg),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    crcbc_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
